// ===== hw/rtl/swbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbm_pkg
// Shared types and constants of the sliding-window bit-rate meter.
// ----------------------------------------------------------------------------
package swbm_pkg;

   localparam int TimeW    = 32;
   localparam int LenW     = 16;
   localparam int RegW     = 16;
   localparam int RateW    = 32;
   localparam int CsrDataW = 32;
   localparam int CsrAddrW = 4;
   localparam int CsrIdxW  = 2;

   // dividend is byte_total * 8
   localparam int DivW     = TimeW + 3;
   localparam int DivCntW  = 6;
   localparam logic [DivCntW-1:0] DivSteps = DivCntW'(DivW);

   localparam logic ACT_RECORD = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   localparam logic [CsrIdxW-1:0] REG_QUERY_WINDOW  = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_RECORD_WINDOW = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_MIN_DURATION  = 2'd2;

   localparam logic [RegW-1:0] QUERY_WINDOW_RST  = 16'd20;
   localparam logic [RegW-1:0] RECORD_WINDOW_RST = 16'd40;
   localparam logic [RegW-1:0] MIN_DURATION_RST  = 16'd1;

   typedef struct packed {
      logic [RegW-1:0] query_window;
      logic [RegW-1:0] record_window;
      logic [RegW-1:0] min_duration;
   } cfg_type;

   typedef struct packed {
      logic [TimeW-1:0] stamp;
      logic [LenW-1:0]  len;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic drop;
      logic append;
      logic div_start;
      logic div_step;
      logic rate_load;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic fifo_full;
      logic fifo_empty;
      logic dur_ok;
      logic age_old;
      logic div_done;
      logic rsp_free;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FULL_DROP,
      ST_APPEND,
      ST_EV_RD,
      ST_EV_CHK,
      ST_DIV,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/swbm_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbm_csr
// APB-style register file holding the window and minimum-duration settings.
// ----------------------------------------------------------------------------
module swbm_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [swbm_pkg::CsrAddrW-1:0]     csr_paddr,
   input  wire  [swbm_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [swbm_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                              csr_pready,
   output swbm_pkg::cfg_type                 cfg
);

   swbm_pkg::cfg_type cfg_ff, cfg_in;
   logic [swbm_pkg::CsrIdxW-1:0] idx;
   logic wr_en;

   assign idx        = csr_paddr[swbm_pkg::CsrAddrW-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            swbm_pkg::REG_QUERY_WINDOW:
               cfg_in.query_window = csr_pwdata[swbm_pkg::RegW-1:0];
            swbm_pkg::REG_RECORD_WINDOW:
               cfg_in.record_window = csr_pwdata[swbm_pkg::RegW-1:0];
            swbm_pkg::REG_MIN_DURATION:
               cfg_in.min_duration = csr_pwdata[swbm_pkg::RegW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         swbm_pkg::REG_QUERY_WINDOW:
            csr_prdata = swbm_pkg::CsrDataW'(cfg_ff.query_window);
         swbm_pkg::REG_RECORD_WINDOW:
            csr_prdata = swbm_pkg::CsrDataW'(cfg_ff.record_window);
         swbm_pkg::REG_MIN_DURATION:
            csr_prdata = swbm_pkg::CsrDataW'(cfg_ff.min_duration);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.query_window  <= swbm_pkg::QUERY_WINDOW_RST;
         cfg_ff.record_window <= swbm_pkg::RECORD_WINDOW_RST;
         cfg_ff.min_duration  <= swbm_pkg::MIN_DURATION_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/swbm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbm_datapath
// Entry FIFO memory, byte total, window start, radix-2 divider and the
// result output register.
// ----------------------------------------------------------------------------
module swbm_datapath #(
   parameter int FIFO_DEPTH = 64
) (
   input  wire                               clock,
   input  wire                               reset,
   input  swbm_pkg::cmd_type                 cmd,
   output swbm_pkg::status_type              status,
   input  swbm_pkg::cfg_type                 cfg,
   input  wire                               req_action,
   input  wire  [swbm_pkg::TimeW-1:0]        req_now_ms,
   input  wire  [swbm_pkg::LenW-1:0]         req_packet_len,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [swbm_pkg::RateW-1:0]        rsp_tdata
);

   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int SW = AW + 1;
   localparam int TW = swbm_pkg::TimeW;

   swbm_pkg::entry_type mem [FIFO_DEPTH];
   swbm_pkg::entry_type rd_data_ff;

   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [TW-1:0]  total_ff, total_in;
   logic [TW-1:0]  wstart_ff, wstart_in;
   logic           started_ff, started_in;
   logic           action_ff;
   logic [TW-1:0]  now_ff;
   logic [swbm_pkg::LenW-1:0] len_ff;
   logic [swbm_pkg::RateW-1:0] rate_ff, rate_in;
   logic [swbm_pkg::DivW-1:0]  dq_ff, dq_in;
   logic [TW-1:0]  rem_ff, rem_in;
   logic [swbm_pkg::DivCntW-1:0] dcnt_ff, dcnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [swbm_pkg::RateW-1:0] rsp_data_ff;

   logic [SW-1:0]  tail_sum;
   logic [AW-1:0]  tail;
   logic [AW-1:0]  head_next;
   logic [TW-1:0]  duration;
   logic [TW-1:0]  age;
   logic [swbm_pkg::RegW-1:0] window;
   logic [TW:0]    trial;
   logic           trial_ge;

   // tail = (head + count) mod depth; the sum stays below twice the depth
   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign tail      = (tail_sum >= SW'(FIFO_DEPTH)) ? AW'(tail_sum - SW'(FIFO_DEPTH))
                                                    : tail_sum[AW-1:0];
   assign head_next = (head_ff == AW'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign duration = now_ff - wstart_ff;
   assign age      = now_ff - rd_data_ff.stamp;
   assign window   = (action_ff == swbm_pkg::ACT_QUERY) ? cfg.query_window
                                                        : cfg.record_window;

   assign trial    = {rem_ff, dq_ff[swbm_pkg::DivW-1]};
   assign trial_ge = trial >= {1'b0, duration};

   always_comb begin
      status.is_query   = (action_ff == swbm_pkg::ACT_QUERY);
      status.fifo_full  = (count_ff == CW'(FIFO_DEPTH));
      status.fifo_empty = (count_ff == '0);
      // a minimum of zero behaves as one
      status.dur_ok     = (duration != '0) && (duration >= TW'(cfg.min_duration));
      status.age_old    = (age >= TW'(window));
      status.div_done   = (dcnt_ff == '0);
      status.rsp_free   = ~rsp_valid_ff | rsp_tready;
   end

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      wstart_in  = wstart_ff;
      started_in = started_ff;
      rate_in    = rate_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      dcnt_in    = dcnt_ff;

      if (cmd.accept && !started_ff) begin
         wstart_in  = req_now_ms;
         started_in = 1'b1;
      end
      if (cmd.append) begin
         count_in = count_ff + 1'b1;
         total_in = total_ff + TW'(len_ff);
      end
      if (cmd.drop) begin
         head_in   = head_next;
         count_in  = count_ff - 1'b1;
         total_in  = total_ff - TW'(rd_data_ff.len);
         wstart_in = (action_ff == swbm_pkg::ACT_QUERY) ? rd_data_ff.stamp : now_ff;
      end
      if (cmd.div_start) begin
         dq_in   = {total_ff, 3'b000};
         rem_in  = '0;
         dcnt_in = swbm_pkg::DivSteps;
      end
      if (cmd.div_step) begin
         dq_in   = {dq_ff[swbm_pkg::DivW-2:0], trial_ge};
         rem_in  = trial_ge ? TW'(trial - {1'b0, duration}) : trial[TW-1:0];
         dcnt_in = dcnt_ff - 1'b1;
      end
      if (cmd.rate_load) begin
         rate_in = (|dq_ff[swbm_pkg::DivW-1:TW]) ? '1 : dq_ff[TW-1:0];
      end

      if (cmd.rsp_load)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         wstart_ff    <= '0;
         started_ff   <= 1'b0;
         rate_ff      <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         wstart_ff    <= wstart_in;
         started_ff   <= started_in;
         rate_ff      <= rate_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      if (cmd.accept) begin
         action_ff <= req_action;
         now_ff    <= req_now_ms;
         len_ff    <= req_packet_len;
      end
      if (cmd.rsp_load)
         rsp_data_ff <= rate_ff;
   end

   // entry store: one write port at the tail, one registered read at the head
   always_ff @(posedge clock) begin
      if (cmd.append)
         mem[tail] <= '{stamp: now_ff, len: len_ff};
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[head_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/swbm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbm_ctrl
// Sequencer for record and query transactions: full-FIFO drop, append,
// division and the eviction walk.
// ----------------------------------------------------------------------------
module swbm_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  swbm_pkg::status_type   status,
   output swbm_pkg::cmd_type      cmd
);

   swbm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= swbm_pkg::ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;

      unique case (state_ff)
         swbm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = swbm_pkg::ST_DISPATCH;
            end
         end
         swbm_pkg::ST_DISPATCH: begin
            if (status.is_query) begin
               if (status.dur_ok) begin
                  cmd.div_start = 1'b1;
                  state_in      = swbm_pkg::ST_DIV;
               end else begin
                  state_in = swbm_pkg::ST_RESP;
               end
            end else if (status.fifo_full) begin
               state_in = swbm_pkg::ST_FULL_DROP;
            end else begin
               state_in = swbm_pkg::ST_APPEND;
            end
         end
         swbm_pkg::ST_FULL_DROP: begin
            cmd.drop = 1'b1;
            state_in = swbm_pkg::ST_APPEND;
         end
         swbm_pkg::ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = swbm_pkg::ST_EV_RD;
         end
         // wait for the head entry to come out of the memory
         swbm_pkg::ST_EV_RD: begin
            if (!status.fifo_empty)
               state_in = swbm_pkg::ST_EV_CHK;
            else if (status.is_query)
               state_in = swbm_pkg::ST_RESP;
            else
               state_in = swbm_pkg::ST_IDLE;
         end
         swbm_pkg::ST_EV_CHK: begin
            if (status.age_old) begin
               cmd.drop = 1'b1;
               state_in = swbm_pkg::ST_EV_RD;
            end else if (status.is_query) begin
               state_in = swbm_pkg::ST_RESP;
            end else begin
               state_in = swbm_pkg::ST_IDLE;
            end
         end
         swbm_pkg::ST_DIV: begin
            if (status.div_done) begin
               cmd.rate_load = 1'b1;
               state_in      = swbm_pkg::ST_EV_RD;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         swbm_pkg::ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = swbm_pkg::ST_IDLE;
            end
         end
         default: state_in = swbm_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sliding_window_bitrate_meter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_bitrate_meter_unit
// Bit-rate meter over a sliding millisecond window of packet records.
// ----------------------------------------------------------------------------
// Record transactions (tuser 0) append a packet to an entry FIFO and then
// drop entries whose age has reached the record window; they return nothing.
// Query transactions (tuser 1) compute byte_total*8/duration in kbit/s when
// the window is long enough, drop entries whose age has reached the query
// window and return the last rate on the rsp channel. One transaction is
// in work at a time. A record drops the head entry first when the FIFO is
// full, then appends and runs the eviction walk; each dropped entry needs
// one memory read on the single read port. A query runs the 35-step
// radix-2 divider and then the eviction walk; a query whose window is too
// short skips both. A finished result waits in the output register while
// the next transaction is accepted. The entry memory needs no clearing
// after reset.
// ----------------------------------------------------------------------------
module sliding_window_bitrate_meter_unit #(
   parameter int FIFO_DEPTH = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // now_ms[31:0], packet_len[47:32]
   input  wire  [0:0]  req_tuser,   // action[0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // bitrate_kbps[31:0]
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [3:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   swbm_pkg::cfg_type    cfg;
   swbm_pkg::cmd_type    cmd;
   swbm_pkg::status_type status;

   swbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   swbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swbm_datapath #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .cfg            (cfg),
      .req_action     (req_tuser[0]),
      .req_now_ms     (req_tdata[31:0]),
      .req_packet_len (req_tdata[47:32]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== tb/sliding_window_bitrate_meter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_bitrate_meter_unit_tb
// Self-checking bench for the sliding-window bit-rate meter.
// ----------------------------------------------------------------------------
// Record and query transactions go into the req stream. Each accepted one
// also runs through a bench-side copy of the entry FIFO, byte total and window
// start, which queues the rate that every query has to return. The rsp stream
// is checked against that queue in order. Register settings change only while
// the block is quiet, and every write is read back over the APB port. The
// tests cover directed corner cases, register extremes, random traffic under
// several idle patterns, and a long rsp hold-off that backs the block up.
// ----------------------------------------------------------------------------
module sliding_window_bitrate_meter_unit_tb;

   localparam int DEPTH         = 64;
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RATE_SLOTS    = 16;
   // index past the last register, writes to it must be ignored
   localparam logic [swbm_pkg::CsrIdxW-1:0] REG_SPARE = 2'd3;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [47:0]                   req_tdata;   // now_ms[31:0], packet_len[47:32]
   logic [0:0]                    req_tuser;   // action[0]
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [31:0]                   rsp_tdata;   // bitrate_kbps[31:0]
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [swbm_pkg::CsrAddrW-1:0] csr_paddr;
   logic [31:0]                   csr_pwdata;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   // bench copy of the meter state
   swbm_pkg::cfg_type             meter_cfg;
   logic [swbm_pkg::LenW-1:0]     fifo_len [DEPTH];
   logic [swbm_pkg::TimeW-1:0]    fifo_stamp [DEPTH];
   int unsigned                   fifo_head;
   int unsigned                   fifo_count;
   logic [31:0]                   byte_sum;
   logic [swbm_pkg::TimeW-1:0]    win_start;
   logic [swbm_pkg::RateW-1:0]    rate_held;
   bit                            win_started;
   // expected rates, in order of the queries
   logic [swbm_pkg::RateW-1:0]    rate_fifo [RATE_SLOTS];
   logic [3:0]                    rate_wr_ptr;
   logic [3:0]                    rate_rd_ptr;
   int unsigned                   rate_put_total;
   int unsigned                   rate_take_total;
   logic [swbm_pkg::RateW-1:0]    expected_rate;

   int unsigned                   mismatch_count;
   int unsigned                   cycle_count;
   int unsigned                   send_idle_pct;
   int unsigned                   stall_pct;
   int unsigned                   hold_left;
   logic [swbm_pkg::TimeW-1:0]    wall_ms;

   sliding_window_bitrate_meter_unit #(.FIFO_DEPTH(DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] expv,
                                  input logic [31:0] gotv);
      $display("mismatch %s: expected %0d, got %0d at %0t", what, expv, gotv, $time);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------- predictor
   function automatic void rate_put(input logic [swbm_pkg::RateW-1:0] rate);
      rate_fifo[rate_wr_ptr] = rate;
      rate_wr_ptr = rate_wr_ptr + 4'd1;
      rate_put_total++;
   endfunction

   function automatic logic [swbm_pkg::TimeW-1:0] pop_entry();
      logic [swbm_pkg::TimeW-1:0] stamp;
      stamp = fifo_stamp[fifo_head];
      byte_sum = byte_sum - 32'(fifo_len[fifo_head]);
      fifo_head = (fifo_head + 1) % DEPTH;
      fifo_count--;
      return stamp;
   endfunction

   function automatic void predict_rate(input logic action,
                                        input logic [swbm_pkg::TimeW-1:0] now,
                                        input logic [swbm_pkg::LenW-1:0] len);
      logic [swbm_pkg::TimeW-1:0] dur;
      logic [swbm_pkg::TimeW-1:0] min_d;
      logic [swbm_pkg::DivW-1:0]  quot;
      int unsigned                tail;
      if (!win_started) begin
         win_start = now;
         win_started = 1'b1;
      end
      if (action == swbm_pkg::ACT_RECORD) begin
         if (fifo_count >= DEPTH) begin
            void'(pop_entry());
            win_start = now;
         end
         tail = (fifo_head + fifo_count) % DEPTH;
         fifo_len[tail] = len;
         fifo_stamp[tail] = now;
         fifo_count++;
         byte_sum = byte_sum + 32'(len);
         while (fifo_count > 0 &&
                swbm_pkg::TimeW'(now - fifo_stamp[fifo_head]) >=
                swbm_pkg::TimeW'(meter_cfg.record_window)) begin
            void'(pop_entry());
            win_start = now;
         end
      end else begin
         // a zero minimum behaves as one ms, no divide by zero
         min_d = (meter_cfg.min_duration == '0) ? swbm_pkg::TimeW'(1)
                                                 : swbm_pkg::TimeW'(meter_cfg.min_duration);
         dur = now - win_start;
         if (dur >= min_d) begin
            quot = {byte_sum, 3'b000} / swbm_pkg::DivW'(dur);
            rate_held = (quot > swbm_pkg::DivW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : quot[31:0];
            // query evictions pull the window start back to the dropped stamp
            while (fifo_count > 0 &&
                   swbm_pkg::TimeW'(now - fifo_stamp[fifo_head]) >=
                   swbm_pkg::TimeW'(meter_cfg.query_window)) begin
               win_start = pop_entry();
            end
         end
         rate_put(rate_held);
      end
   endfunction

   // ---------------------------------------------------------------- rsp side
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (rate_put_total == rate_take_total) begin
            report_mismatch("unexpected rate transaction", '0, rsp_tdata);
         end else begin
            expected_rate = rate_fifo[rate_rd_ptr];
            rate_rd_ptr = rate_rd_ptr + 4'd1;
            rate_take_total++;
            if (rsp_tdata !== expected_rate)
               report_mismatch("bitrate_kbps", expected_rate, rsp_tdata);
         end
      end
   end

   // ---------------------------------------------------------------- req side
   // entered at a falling edge; valid may stay high with stale data on return,
   // the next call or settle() overwrites it before the next rising edge
   task automatic send_item(input logic action, input logic [swbm_pkg::TimeW-1:0] now,
                            input logic [swbm_pkg::LenW-1:0] len);
      req_tvalid = 1'b1;
      req_tuser  = action;
      req_tdata  = {len, now};
      do @(posedge clock); while (!req_tready);
      predict_rate(action, now, len);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // records give no rsp, so wait out the longest eviction walk as well
   task automatic settle();
      req_tvalid = 1'b0;
      while (rate_put_total != rate_take_total) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------- csr side
   task automatic csr_write(input logic [swbm_pkg::CsrIdxW-1:0] idx,
                            input logic [swbm_pkg::RegW-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = {16'($urandom), value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         swbm_pkg::REG_QUERY_WINDOW:  meter_cfg.query_window  = value;
         swbm_pkg::REG_RECORD_WINDOW: meter_cfg.record_window = value;
         swbm_pkg::REG_MIN_DURATION:  meter_cfg.min_duration  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic csr_check(input logic [swbm_pkg::CsrIdxW-1:0] idx);
      logic [31:0] expv;
      case (idx)
         swbm_pkg::REG_QUERY_WINDOW:  expv = {16'b0, meter_cfg.query_window};
         swbm_pkg::REG_RECORD_WINDOW: expv = {16'b0, meter_cfg.record_window};
         default:                     expv = {16'b0, meter_cfg.min_duration};
      endcase
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = {idx, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== expv)
         report_mismatch("register readback", expv, csr_prdata);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_config(input logic [swbm_pkg::RegW-1:0] query_win,
                             input logic [swbm_pkg::RegW-1:0] record_win,
                             input logic [swbm_pkg::RegW-1:0] min_dur);
      settle();
      csr_write(swbm_pkg::REG_QUERY_WINDOW, query_win);
      csr_write(swbm_pkg::REG_RECORD_WINDOW, record_win);
      csr_write(swbm_pkg::REG_MIN_DURATION, min_dur);
      csr_check(swbm_pkg::REG_QUERY_WINDOW);
      csr_check(swbm_pkg::REG_RECORD_WINDOW);
      csr_check(swbm_pkg::REG_MIN_DURATION);
   endtask

   // random traffic: mostly small forward steps, some jumps and some time going back
   task automatic run_random(input int unsigned count, input int unsigned step_max,
                             input int unsigned query_pct);
      logic                      act;
      logic [swbm_pkg::LenW-1:0] len;
      int unsigned               pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 2)
            wall_ms = $urandom;
         else if (pick < 4)
            wall_ms = wall_ms - $urandom_range(1, 2000);
         else
            wall_ms = wall_ms + $urandom_range(0, step_max);
         pick = $urandom_range(99);
         len = (pick < 5) ? 16'h0000 : (pick < 10) ? 16'hFFFF : 16'($urandom);
         act = ($urandom_range(99) < query_pct) ? swbm_pkg::ACT_QUERY : swbm_pkg::ACT_RECORD;
         send_item(act, wall_ms, len);
      end
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct = 0;
      send_item(swbm_pkg::ACT_QUERY, 32'd1000, 16'h0000);  // first transaction opens the window
      send_item(swbm_pkg::ACT_RECORD, 32'd1000, 16'h0000);
      send_item(swbm_pkg::ACT_RECORD, 32'd1001, 16'hFFFF);
      send_item(swbm_pkg::ACT_RECORD, 32'd1005, 16'd1500);
      send_item(swbm_pkg::ACT_QUERY, 32'd1010, 16'h0000);
      send_item(swbm_pkg::ACT_QUERY, 32'd1030, 16'h0000);  // query window drops all three entries
      send_item(swbm_pkg::ACT_QUERY, 32'd1001, 16'hFFFF);  // time goes back, duration wraps
      send_item(swbm_pkg::ACT_RECORD, 32'd1100, 16'd200);  // FIFO already empty, nothing to drop
      send_item(swbm_pkg::ACT_QUERY, 32'd1101, 16'h0000);
      send_item(swbm_pkg::ACT_RECORD, 32'hFFFF_FFF0, 16'd7);
      send_item(swbm_pkg::ACT_RECORD, 32'h0000_0005, 16'd9); // stamp wraps
      send_item(swbm_pkg::ACT_QUERY, 32'h0000_0008, 16'h0000);
      send_item(swbm_pkg::ACT_RECORD, 32'h0000_0000, 16'hFFFF);
      send_item(swbm_pkg::ACT_QUERY, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(swbm_pkg::ACT_RECORD, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(swbm_pkg::ACT_QUERY, 32'hFFFF_FFFF, 16'h0000);
      send_item(swbm_pkg::ACT_QUERY, 32'h0000_0040, 16'h0000);
   endtask

   task automatic test_register_extremes();
      // zero windows drop everything, zero minimum acts as one
      set_config(16'd0, 16'd0, 16'd0);
      send_item(swbm_pkg::ACT_RECORD, 32'd100, 16'd5);
      send_item(swbm_pkg::ACT_QUERY, 32'd100, 16'h0000);
      send_item(swbm_pkg::ACT_QUERY, 32'd101, 16'h0000);
      send_item(swbm_pkg::ACT_RECORD, 32'd101, 16'hFFFF);
      send_item(swbm_pkg::ACT_QUERY, 32'd150, 16'h0000);
      settle();
      csr_write(REG_SPARE, 16'hFFFF);
      csr_check(swbm_pkg::REG_QUERY_WINDOW);
      csr_check(swbm_pkg::REG_RECORD_WINDOW);
      csr_check(swbm_pkg::REG_MIN_DURATION);
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(swbm_pkg::ACT_QUERY, 32'd200, 16'h0000);
      send_item(swbm_pkg::ACT_RECORD, 32'd200, 16'hFFFF);
      send_item(swbm_pkg::ACT_RECORD, 32'd65735, 16'd33);  // age equals the window
      send_item(swbm_pkg::ACT_QUERY, 32'd131270, 16'h0000);
      send_item(swbm_pkg::ACT_QUERY, 32'd200000, 16'h0000);
      set_config(16'd1, 16'd1, 16'd1);
      send_item(swbm_pkg::ACT_RECORD, 32'd300000, 16'd7);
      send_item(swbm_pkg::ACT_QUERY, 32'd300001, 16'h0000);
      send_item(swbm_pkg::ACT_RECORD, 32'd300001, 16'd11);
      send_item(swbm_pkg::ACT_QUERY, 32'd300001, 16'h0000);
   endtask

   task automatic test_idle_free();
      set_config(16'd20, 16'd40, 16'd1);
      send_idle_pct = 0;
      stall_pct = 0;
      wall_ms = 32'hFFFF_FC00;
      run_random(380, 8, 30);
   endtask

   task automatic test_sender_gaps();
      // wide record window and slow time fill the FIFO
      set_config(16'($urandom_range(1, 400)), 16'hFFFF, 16'($urandom_range(1, 50)));
      send_idle_pct = 86;
      stall_pct = 0;
      run_random(380, 1, 25);
   endtask

   task automatic test_receiver_stalls();
      set_config(16'($urandom), 16'($urandom), 16'($urandom));
      send_idle_pct = 0;
      stall_pct = 86;
      run_random(380, 3000, 40);
   endtask

   task automatic test_mixed_idling();
      set_config(16'd1, 16'd1, 16'hFFFF);
      send_idle_pct = 27;
      stall_pct = 27;
      run_random(190, 70000, 35);
      set_config(16'hFFFF, 16'd2000, 16'd0);
      run_random(190, 50, 35);
   endtask

   task automatic test_output_backpressure();
      set_config(16'd100, 16'd200, 16'd1);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_left = 1500;    // rsp stays blocked while req keeps offering
      run_random(150, 4, 50);
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      rsp_tready    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      meter_cfg     = '{query_window: swbm_pkg::QUERY_WINDOW_RST,
                        record_window: swbm_pkg::RECORD_WINDOW_RST,
                        min_duration: swbm_pkg::MIN_DURATION_RST};
      fifo_head     = 0;
      fifo_count    = 0;
      byte_sum      = '0;
      win_start     = '0;
      rate_held     = '0;
      win_started   = 1'b0;
      rate_wr_ptr   = '0;
      rate_rd_ptr   = '0;
      rate_put_total  = 0;
      rate_take_total = 0;
      mismatch_count = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = 0;
      wall_ms       = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_register_extremes();
      test_idle_free();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_output_backpressure();
      settle();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
